// ===== design/pal_pkg.sv =====
package pal_pkg;

    localparam int DEFAULT_LIST_DEPTH = 128;

    localparam int DATA_W = 32;
    localparam int POS_W  = 8;
    localparam int OP_W   = 2;
    localparam int ST_W   = 2;
    localparam int CNT_OUT_W = 8;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
    localparam logic [OP_W-1:0] OP_READ   = 2'd3;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD_POS = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd2;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;      // open a slot at pos, write value there
        logic del;      // close the slot at pos
        logic load;     // snapshot entry at pos into readout lane
        logic shift;    // move readout lane one cell toward cell 0
    } pal_ctrl_t;

endpackage

// ===== design/positional_array_list_core.sv =====
// Packed ordered list of up to LIST_DEPTH signed 32-bit entries, held in a
// row of cells, one entry per cell. Each request is insert at a position,
// append, delete at a position or read at a position, and each gives exactly
// one result with the returned entry, a status (ok, bad position, full), the
// entry count after the operation (low 8 bits) and empty/full flags.
// Insert and append shift every later cell up together, delete shifts them
// down together. Insert, append and any failed request are loaded into the
// output register at the accepting edge, so the result is offered in the
// cycle after acceptance. A good read or delete snapshots the addressed
// entry into a readout lane that runs along the cells and walks one cell
// per cycle toward cell 0; once it reaches cell 0 the entry is loaded into
// the output register (snapshot, walk, output load), later if the previous
// result is still waiting; no new request is taken while it walks. The
// output register lets a new request in while the last result waits, as
// long as the consumer takes it in that same cycle.
module positional_array_list_core
    import pal_pkg::*;
#(
    parameter int LIST_DEPTH = DEFAULT_LIST_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [1:0] operation, [9:2] position, [41:10] value, [47:42] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [31:0] entry_out, [33:32] status, [41:34] count,
    // [42] is_empty_flag, [43] is_full_flag, [47:44] zero
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(LIST_DEPTH);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    // request fields
    logic [OP_W-1:0]          in_op;
    logic [POS_W-1:0]         in_pos;
    logic signed [DATA_W-1:0] in_value;

    assign in_op    = s_tdata[OP_W-1:0];
    assign in_pos   = s_tdata[OP_W +: POS_W];
    assign in_value = s_tdata[OP_W+POS_W +: DATA_W];

    logic                     state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [POS_W-1:0]         walk_reg, walk_next;
    logic                     m_valid_reg, m_valid_next;
    logic signed [DATA_W-1:0] m_entry_reg, m_entry_next;
    logic [ST_W-1:0]          m_status_reg, m_status_next;
    logic [CNT_W-1:0]         m_count_reg, m_count_next;

    logic                     out_free;
    logic                     accept;
    logic                     is_full;
    logic [IDX_W-1:0]         pos_x;
    logic [IDX_W-1:0]         count_x;
    logic [IDX_W-1:0]         cell_pos;
    pal_ctrl_t                ctrl;
    logic [ST_W-1:0]          req_status;
    logic                     req_walk;   // good read/delete: result via lane

    logic signed [DATA_W-1:0] entry_w [LIST_DEPTH];
    logic signed [DATA_W-1:0] lane_w  [LIST_DEPTH];

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    assign is_full = (count_reg == FULL_CNT);
    assign pos_x   = IDX_W'(in_pos);
    assign count_x = IDX_W'(count_reg);

    // append is an insert at the current end
    assign cell_pos = (in_op == OP_APPEND) ? count_x : pos_x;

    // decode one request
    always_comb begin
        req_status = ST_OK;
        req_walk   = 1'b0;
        ctrl       = '0;
        case (in_op)
            OP_INSERT: begin
                if (is_full) begin
                    req_status = ST_FULL;
                end else if (pos_x > count_x) begin
                    req_status = ST_BAD_POS;
                end else begin
                    ctrl.ins = accept;
                end
            end
            OP_APPEND: begin
                if (is_full) begin
                    req_status = ST_FULL;
                end else begin
                    ctrl.ins = accept;
                end
            end
            OP_DELETE: begin
                if (pos_x >= count_x) begin
                    req_status = ST_BAD_POS;
                end else begin
                    req_walk  = 1'b1;
                    ctrl.del  = accept;
                    ctrl.load = accept;
                end
            end
            OP_READ: begin
                if (pos_x >= count_x) begin
                    req_status = ST_BAD_POS;
                end else begin
                    req_walk  = 1'b1;
                    ctrl.load = accept;
                end
            end
            default: begin
                req_status = ST_BAD_POS;
            end
        endcase
        ctrl.shift = (state_reg == ST_WALK) && (walk_reg != '0);
    end

    // control and output register
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        walk_next     = walk_reg;
        m_valid_next  = m_valid_reg;
        m_entry_next  = m_entry_reg;
        m_status_next = m_status_reg;
        m_count_next  = m_count_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        if (accept) begin
            if (ctrl.ins) begin
                count_next = count_reg + 1'b1;
            end else if (ctrl.del) begin
                count_next = count_reg - 1'b1;
            end
            if (req_walk) begin
                state_next = ST_WALK;
                walk_next  = in_pos;
            end else begin
                m_valid_next  = 1'b1;
                m_entry_next  = '0;
                m_status_next = req_status;
                m_count_next  = ctrl.ins ? count_reg + 1'b1 : count_reg;
            end
        end else if (state_reg == ST_WALK) begin
            if (walk_reg != '0) begin
                walk_next = walk_reg - 1'b1;
            end else if (out_free) begin
                // entry has reached cell 0
                state_next    = ST_IDLE;
                m_valid_next  = 1'b1;
                m_entry_next  = lane_w[0];
                m_status_next = ST_OK;
                m_count_next  = count_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        walk_reg     <= walk_next;
        m_entry_reg  <= m_entry_next;
        m_status_reg <= m_status_next;
        m_count_reg  <= m_count_next;
    end

    // row of cells; cell i holds list entry i
    for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
        logic signed [DATA_W-1:0] left_e;
        logic signed [DATA_W-1:0] right_e;
        logic signed [DATA_W-1:0] right_l;

        if (i == 0) begin : g_first
            assign left_e = '0;
        end else begin : g_mid_l
            assign left_e = entry_w[i-1];
        end

        if (i == LIST_DEPTH - 1) begin : g_last
            assign right_e = '0;
            assign right_l = '0;
        end else begin : g_mid_r
            assign right_e = entry_w[i+1];
            assign right_l = lane_w[i+1];
        end

        pal_cell #(
            .INDEX (i),
            .IDX_W (IDX_W)
        ) u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .pos         (cell_pos),
            .value       (in_value),
            .left_entry  (left_e),
            .right_entry (right_e),
            .right_lane  (right_l),
            .entry       (entry_w[i]),
            .lane        (lane_w[i])
        );
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {
        4'b0000,
        (m_count_reg == FULL_CNT),
        (m_count_reg == '0),
        CNT_OUT_W'(m_count_reg),
        m_status_reg,
        m_entry_reg
    };

endmodule

// ===== design/pal_cell.sv =====
module pal_cell
    import pal_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int IDX_W = 8
) (
    input  logic                     aclk,
    input  pal_ctrl_t                ctrl,
    input  logic [IDX_W-1:0]         pos,
    input  logic signed [DATA_W-1:0] value,
    input  logic signed [DATA_W-1:0] left_entry,
    input  logic signed [DATA_W-1:0] right_entry,
    input  logic signed [DATA_W-1:0] right_lane,
    output logic signed [DATA_W-1:0] entry,
    output logic signed [DATA_W-1:0] lane
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic signed [DATA_W-1:0] entry_reg, entry_next;
    logic signed [DATA_W-1:0] lane_reg, lane_next;
    logic                     hit;
    logic                     above;

    assign hit   = (pos == MY_IDX);
    assign above = (MY_IDX > pos);

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.ins) begin
            if (hit) begin
                entry_next = value;
            end else if (above) begin
                entry_next = left_entry;
            end
        end else if (ctrl.del) begin
            if (hit || above) begin
                entry_next = right_entry;
            end
        end
    end

    always_comb begin
        lane_next = lane_reg;
        if (ctrl.load) begin
            lane_next = hit ? entry_reg : '0;
        end else if (ctrl.shift) begin
            lane_next = right_lane;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        lane_reg  <= lane_next;
    end

    assign entry = entry_reg;
    assign lane  = lane_reg;

endmodule

// ===== design/pal_checker.sv =====
module pal_checker
    import pal_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic [ST_W-1:0] st;
    logic            empty_f;
    logic            full_f;

    assign st      = m_tdata[DATA_W +: ST_W];
    assign empty_f = m_tdata[DATA_W+ST_W+CNT_OUT_W];
    assign full_f  = m_tdata[DATA_W+ST_W+CNT_OUT_W+1];

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // failed request returns no entry
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (st != ST_OK) |-> (m_tdata[DATA_W-1:0] == '0))
        else $error("failed request returned an entry");

    // full status only when the list is full
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (st == ST_FULL) |-> full_f)
        else $error("full status with list not full");

    // empty flag agrees with count
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && empty_f |-> (m_tdata[DATA_W+ST_W +: CNT_OUT_W] == '0) && !full_f)
        else $error("empty flag inconsistent");

endmodule

bind positional_array_list_core pal_checker u_pal_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
